FILE: rtl/bve_pkg.sv
// Shared constants and types of the bounded vector engine.
package bve_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int KIND_W  = 3;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 7;
    localparam int ERR_W   = 3;
    localparam int COUNT_W = 7;

    typedef logic [KIND_W-1:0]         kind_t;
    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [INDEX_W-1:0] index_t;
    typedef logic [ERR_W-1:0]          err_t;
    typedef logic [COUNT_W-1:0]        count_t;

    localparam kind_t KIND_APPEND     = 3'd0;
    localparam kind_t KIND_TAKE_LAST  = 3'd1;
    localparam kind_t KIND_PREPEND    = 3'd2;
    localparam kind_t KIND_TAKE_FIRST = 3'd3;
    localparam kind_t KIND_INSERT     = 3'd4;
    localparam kind_t KIND_READ_AT    = 3'd5;
    localparam kind_t KIND_FIND       = 3'd6;

    localparam err_t ERR_NONE     = 3'd0;
    localparam err_t ERR_EMPTY    = 3'd1;
    localparam err_t ERR_INDEX    = 3'd2;
    localparam err_t ERR_NOTFOUND = 3'd3;
    localparam err_t ERR_FULL     = 3'd4;

    localparam word_t  FAIL_WORD   = '1;
    localparam index_t INDEX_FRONT = '1;

endpackage

FILE: rtl/bve_if.sv
// Request and response channel interfaces of the bounded vector engine.
interface bve_req_if;
    logic             valid;
    logic             ready;
    bve_pkg::kind_t   kind;
    bve_pkg::word_t   value;
    bve_pkg::index_t  index;

    modport source (output valid, output kind, output value, output index, input ready);
    modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface bve_rsp_if;
    logic             valid;
    logic             ready;
    bve_pkg::word_t   result_value;
    bve_pkg::err_t    error_code;
    bve_pkg::count_t  count;

    modport source (output valid, output result_value, output error_code, output count,
                    input ready);
    modport sink   (input valid, input result_value, input error_code, input count,
                    output ready);
endinterface

FILE: rtl/bounded_vector_engine.sv
// Bounded vector engine: an ordered list of signed words kept in one synchronous RAM.
//
// The list lives in a DEPTH-word RAM with one write and one registered read port,
// and every request word is served one at a time. A back push, an unused kind and
// any operation that fails its full, empty or index check complete without a RAM
// read; a back pop and read_at make one RAM read. A front push and an insert at
// position p move the entries from p up by one, one RAM read and one write per
// cycle; a front pop moves all remaining entries down; find scans from the front
// and stops at the first hit. The single RAM port pair limits each operation, and a
// response word that waits for the receiver delays the next completion.
// A new request word is accepted while the previous response word still waits in the
// output register. No clearing pass is needed after reset.
module bounded_vector_engine #(
    parameter int DEPTH = bve_pkg::DEPTH_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    bve_req_if.sink req,
    bve_rsp_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RDWAIT   = 3'd1;
    localparam logic [2:0] S_SHIFT_UP = 3'd2;
    localparam logic [2:0] S_SHIFT_DN = 3'd3;
    localparam logic [2:0] S_FIND     = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        occ_reg, occ_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]        last_reg, last_next;
    logic                 issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    bve_pkg::word_t       val_reg, val_next;
    bve_pkg::word_t       res_reg, res_next;
    bve_pkg::err_t        err_reg, err_next;

    logic                 out_valid_reg, out_valid_next;
    bve_pkg::word_t       out_value_reg, out_value_next;
    bve_pkg::err_t        out_err_reg, out_err_next;
    bve_pkg::count_t      out_count_reg, out_count_next;

    bve_pkg::word_t       mem [DEPTH];
    bve_pkg::word_t       rdata_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    bve_pkg::word_t       mem_wdata;
    logic [AW-1:0]        mem_raddr;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [CW-1:0]        occ_dec;
    logic [CW+6:0]        occ_wide;
    logic [CW+6:0]        idx_wide;
    logic                 idx_ok;
    logic [AW-1:0]        idx_addr;
    logic                 out_load;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign full     = (occ_reg == FULL_COUNT);
    assign empty    = (occ_reg == '0);
    assign occ_dec  = occ_reg - 1'b1;
    assign occ_wide = {7'b0, occ_reg};
    assign idx_wide = {{(CW + 1){1'b0}}, req.index[5:0]};
    assign idx_ok   = !req.index[6] && (idx_wide < occ_wide);
    assign idx_addr = idx_wide[AW-1:0];
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.error_code   = out_err_reg;
    assign rsp.count        = out_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        rd_ptr_next    = rd_ptr_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = val_reg;
        mem_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next   = req.value;
                    res_next   = '0;
                    err_next   = bve_pkg::ERR_NONE;
                    issue_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    case (req.kind)
                        bve_pkg::KIND_APPEND:
                        begin
                            if (full)
                            begin
                                res_next = bve_pkg::FAIL_WORD;
                                err_next = bve_pkg::ERR_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = occ_reg[AW-1:0];
                                mem_wdata = req.value;
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        bve_pkg::KIND_TAKE_LAST:
                        begin
                            if (empty)
                            begin
                                res_next = bve_pkg::FAIL_WORD;
                                err_next = bve_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                mem_raddr  = occ_dec[AW-1:0];
                                occ_next   = occ_dec;
                                state_next = S_RDWAIT;
                            end
                        end
                        bve_pkg::KIND_PREPEND,
                        bve_pkg::KIND_INSERT:
                        begin
                            if (full)
                            begin
                                res_next = bve_pkg::FAIL_WORD;
                                err_next = bve_pkg::ERR_FULL;
                            end
                            else if (req.kind == bve_pkg::KIND_INSERT &&
                                     req.index != bve_pkg::INDEX_FRONT && !idx_ok)
                            begin
                                res_next = bve_pkg::FAIL_WORD;
                                err_next = bve_pkg::ERR_INDEX;
                            end
                            else if (empty)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = req.value;
                                occ_next  = occ_reg + 1'b1;
                            end
                            else
                            begin
                                // The target slot; the entries from it upward move up by one.
                                if (req.kind == bve_pkg::KIND_INSERT &&
                                    req.index != bve_pkg::INDEX_FRONT)
                                begin
                                    last_next = idx_addr;
                                end
                                else
                                begin
                                    last_next = '0;
                                end
                                rd_ptr_next = occ_dec[AW-1:0];
                                state_next  = S_SHIFT_UP;
                            end
                        end
                        bve_pkg::KIND_TAKE_FIRST:
                        begin
                            if (empty)
                            begin
                                res_next = bve_pkg::FAIL_WORD;
                                err_next = bve_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                rd_ptr_next = '0;
                                last_next   = occ_dec[AW-1:0];
                                state_next  = S_SHIFT_DN;
                            end
                        end
                        bve_pkg::KIND_READ_AT:
                        begin
                            if (!idx_ok)
                            begin
                                res_next = bve_pkg::FAIL_WORD;
                                err_next = bve_pkg::ERR_INDEX;
                            end
                            else
                            begin
                                mem_raddr  = idx_addr;
                                state_next = S_RDWAIT;
                            end
                        end
                        bve_pkg::KIND_FIND:
                        begin
                            if (empty)
                            begin
                                res_next = bve_pkg::FAIL_WORD;
                                err_next = bve_pkg::ERR_NOTFOUND;
                            end
                            else
                            begin
                                rd_ptr_next = '0;
                                last_next   = occ_dec[AW-1:0];
                                state_next  = S_FIND;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res_next   = rdata_reg;
                state_next = S_DONE;
            end
            S_SHIFT_UP,
            S_SHIFT_DN,
            S_FIND:
            begin
                // Reads are issued one per cycle; each lands in rdata_reg in the cycle after.
                mem_raddr      = rd_ptr_reg;
                pend_addr_next = rd_ptr_reg;
                pend_next      = issue_reg;
                if (issue_reg)
                begin
                    if (rd_ptr_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else if (state_reg == S_SHIFT_UP)
                    begin
                        rd_ptr_next = rd_ptr_reg - 1'b1;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end

                if (state_reg == S_SHIFT_UP)
                begin
                    if (pend_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_addr_reg + 1'b1;
                        mem_wdata = rdata_reg;
                    end
                    else if (!issue_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = last_reg;
                        mem_wdata  = val_reg;
                        occ_next   = occ_reg + 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (state_reg == S_SHIFT_DN)
                begin
                    if (pend_reg)
                    begin
                        if (pend_addr_reg == '0)
                        begin
                            res_next = rdata_reg;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg - 1'b1;
                            mem_wdata = rdata_reg;
                        end
                    end
                    else if (!issue_reg)
                    begin
                        occ_next   = occ_dec;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    if (pend_reg && rdata_reg == val_reg)
                    begin
                        res_next   = 32'(pend_addr_reg);
                        state_next = S_DONE;
                    end
                    else if (!issue_reg && pend_reg)
                    begin
                        res_next   = bve_pkg::FAIL_WORD;
                        err_next   = bve_pkg::ERR_NOTFOUND;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_value_next = res_reg;
            out_err_next   = err_reg;
            out_count_next = occ_wide[6:0];
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        res_reg       <= res_next;
        err_reg       <= err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_COUNT)
        else $error("occupancy exceeds depth");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |->
            (occ_reg == $past(occ_reg) + 1'b1 || occ_reg == $past(occ_reg) - 1'b1))
        else $error("occupancy moved by more than one");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("response word raised outside completion");

    a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.error_code != bve_pkg::ERR_NONE) |->
            rsp.result_value == bve_pkg::FAIL_WORD)
        else $error("failed operation without fail word");

endmodule

FILE: tb/bounded_vector_engine_tb.sv
// Self-checking testbench for the bounded vector engine: a directed table, then random traffic.
`timescale 1ns / 100ps

module bounded_vector_engine_tb;

    localparam int             DEPTH        = bve_pkg::DEPTH_DEFAULT;
    localparam int             RANDOM_ITEMS = 618;
    localparam int             STALL_LIMIT  = 4000;
    localparam int             TAIL_CYCLES  = 3 * DEPTH;
    localparam int             MAX_REPORTS  = 10;
    localparam bve_pkg::kind_t KIND_UNUSED  = 3'd7;

    typedef struct packed {
        bve_pkg::word_t  result_value;
        bve_pkg::err_t   error_code;
        bve_pkg::count_t count;
    } reply_t;

    typedef struct packed {
        bve_pkg::kind_t  kind;
        bve_pkg::word_t  value;
        bve_pkg::index_t index;
        logic            known;
        reply_t          reply;
    } op_row_t;

    // Rows with known set carry their reply; the others are left to the list model.
    op_row_t directed_ops [25] = '{
        '{bve_pkg::KIND_TAKE_LAST,  32'sd0,         7'sd0,   1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_EMPTY, 7'd0}},
        '{bve_pkg::KIND_TAKE_FIRST, 32'sd0,         7'sd0,   1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_EMPTY, 7'd0}},
        '{bve_pkg::KIND_READ_AT,    32'sd0,         7'sd0,   1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_INDEX, 7'd0}},
        '{bve_pkg::KIND_FIND,       32'sd0,         7'sd0,   1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_NOTFOUND, 7'd0}},
        '{bve_pkg::KIND_INSERT,     32'sd5,         7'sd0,   1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_INDEX, 7'd0}},
        '{KIND_UNUSED,              32'sd9,         7'sd3,   1'b1,
          '{32'sd0, bve_pkg::ERR_NONE, 7'd0}},
        '{bve_pkg::KIND_INSERT,     32'sh7FFF_FFFF, bve_pkg::INDEX_FRONT, 1'b1,
          '{32'sd0, bve_pkg::ERR_NONE, 7'd1}},
        '{bve_pkg::KIND_APPEND,     32'sh8000_0000, 7'sd0,   1'b1,
          '{32'sd0, bve_pkg::ERR_NONE, 7'd2}},
        '{bve_pkg::KIND_PREPEND,    32'sd0,         7'sd0,   1'b1,
          '{32'sd0, bve_pkg::ERR_NONE, 7'd3}},
        '{bve_pkg::KIND_READ_AT,    32'sd0,         7'sd2,   1'b1,
          '{32'sh8000_0000, bve_pkg::ERR_NONE, 7'd3}},
        '{bve_pkg::KIND_READ_AT,    32'sd0,         7'sd3,   1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_INDEX, 7'd3}},
        // The most negative index, then the largest positive one.
        '{bve_pkg::KIND_READ_AT,    32'sd0,         7'sh40,  1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_INDEX, 7'd3}},
        '{bve_pkg::KIND_READ_AT,    32'sd0,         7'sd63,  1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_INDEX, 7'd3}},
        '{bve_pkg::KIND_READ_AT,    32'sd0,         -7'sd1,  1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_INDEX, 7'd3}},
        '{bve_pkg::KIND_INSERT,     32'sd1,         7'sd3,   1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_INDEX, 7'd3}},
        '{bve_pkg::KIND_INSERT,     32'sd1,         -7'sd2,  1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_INDEX, 7'd3}},
        '{bve_pkg::KIND_INSERT,     -32'sd1,        7'sd1,   1'b0, '0},
        '{bve_pkg::KIND_APPEND,     -32'sd1,        7'sd0,   1'b0, '0},
        // Two equal entries: the lower position must win.
        '{bve_pkg::KIND_FIND,       -32'sd1,        7'sd0,   1'b0, '0},
        '{bve_pkg::KIND_FIND,       32'sh8000_0000, 7'sd0,   1'b0, '0},
        '{bve_pkg::KIND_FIND,       32'sd12345,     7'sd0,   1'b1,
          '{bve_pkg::FAIL_WORD, bve_pkg::ERR_NOTFOUND, 7'd5}},
        '{KIND_UNUSED,              32'sd0,         -7'sd1,  1'b0, '0},
        '{bve_pkg::KIND_TAKE_FIRST, 32'sd0,         7'sd0,   1'b0, '0},
        '{bve_pkg::KIND_TAKE_LAST,  32'sd0,         7'sd0,   1'b0, '0},
        '{bve_pkg::KIND_READ_AT,    32'sd0,         7'sd0,   1'b0, '0}
    };

    logic           clk = 1'b0;
    logic           rst_n;
    int             snd_idle_pct;
    int             rcv_idle_pct;
    logic           known_reply;
    reply_t         known_value;
    bve_pkg::word_t list_mem [DEPTH];
    int             list_len;
    logic           growing;
    reply_t         pending_replies [$];
    int             failures;
    int             quiet_cycles;

    bve_req_if req_ch ();
    bve_rsp_if rsp_ch ();

    bounded_vector_engine #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

    // Opens a gap at pos and stores w there.
    function automatic void open_slot(int pos, bve_pkg::word_t w);
        for (int i = list_len; i > pos; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[pos] = w;
        list_len++;
    endfunction

    function automatic reply_t apply_list_op(bve_pkg::kind_t kind, bve_pkg::word_t value,
                                             bve_pkg::index_t index);
        reply_t r;
        int     ix;
        ix             = int'(index);
        r.result_value = '0;
        r.error_code   = bve_pkg::ERR_NONE;
        case (kind)
            bve_pkg::KIND_APPEND, bve_pkg::KIND_PREPEND, bve_pkg::KIND_INSERT:
            begin
                // A full list is reported before any index check.
                if (list_len >= DEPTH)
                begin
                    r.result_value = bve_pkg::FAIL_WORD;
                    r.error_code   = bve_pkg::ERR_FULL;
                end
                else if (kind == bve_pkg::KIND_APPEND)
                    open_slot(list_len, value);
                else if (kind == bve_pkg::KIND_PREPEND || index == bve_pkg::INDEX_FRONT)
                    open_slot(0, value);
                else if (ix < 0 || ix >= list_len)
                begin
                    r.result_value = bve_pkg::FAIL_WORD;
                    r.error_code   = bve_pkg::ERR_INDEX;
                end
                else
                    open_slot(ix, value);
            end
            bve_pkg::KIND_TAKE_LAST, bve_pkg::KIND_TAKE_FIRST:
            begin
                if (list_len == 0)
                begin
                    r.result_value = bve_pkg::FAIL_WORD;
                    r.error_code   = bve_pkg::ERR_EMPTY;
                end
                else if (kind == bve_pkg::KIND_TAKE_LAST)
                begin
                    list_len--;
                    r.result_value = list_mem[list_len];
                end
                else
                begin
                    r.result_value = list_mem[0];
                    for (int i = 1; i < list_len; i++)
                        list_mem[i-1] = list_mem[i];
                    list_len--;
                end
            end
            bve_pkg::KIND_READ_AT:
            begin
                if (ix < 0 || ix >= list_len)
                begin
                    r.result_value = bve_pkg::FAIL_WORD;
                    r.error_code   = bve_pkg::ERR_INDEX;
                end
                else
                    r.result_value = list_mem[ix];
            end
            bve_pkg::KIND_FIND:
            begin
                r.result_value = bve_pkg::FAIL_WORD;
                r.error_code   = bve_pkg::ERR_NOTFOUND;
                // Scanning downward leaves the lowest match in place.
                for (int i = list_len - 1; i >= 0; i--)
                begin
                    if (list_mem[i] == value)
                    begin
                        r.result_value = bve_pkg::word_t'(i);
                        r.error_code   = bve_pkg::ERR_NONE;
                    end
                end
            end
            default: ;
        endcase
        r.count = bve_pkg::count_t'(list_len);
        return r;
    endfunction

    // Checks response words against the oldest pending reply and models accepted requests.
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        logic   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                got   = '{rsp_ch.result_value, rsp_ch.error_code, rsp_ch.count};
                if (pending_replies.size() == 0)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display({"%0t: response word with none pending:",
                                  " value %0d err %0d count %0d"},
                                 $time, got.result_value, got.error_code, got.count);
                end
                else
                begin
                    want = pending_replies[0];
                    pending_replies.delete(0);
                    if (got.result_value !== want.result_value
                        || got.error_code !== want.error_code
                        || got.count !== want.count)
                    begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display({"%0t: mismatch: expected value %0d err %0d count %0d,",
                                      " got value %0d err %0d count %0d"},
                                     $time, want.result_value, want.error_code, want.count,
                                     got.result_value, got.error_code, got.count);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                want  = apply_list_op(req_ch.kind, req_ch.value, req_ch.index);
                if (known_reply)
                    want = known_value;
                pending_replies = {pending_replies, want};
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_op(bve_pkg::kind_t kind, bve_pkg::word_t value,
                           bve_pkg::index_t index, logic known, reply_t reply);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        req_ch.index <= index;
        known_reply  <= known;
        known_value  <= reply;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Holds the request side idle until every pending reply has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
    endtask

    initial
    begin
        int              sent;
        int              roll;
        bve_pkg::kind_t  kind;
        bve_pkg::word_t  value;
        bve_pkg::index_t index;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind  = bve_pkg::KIND_APPEND;
        req_ch.value = '0;
        req_ch.index = '0;
        known_reply  = 1'b0;
        known_value  = '0;
        list_len     = 0;
        growing      = 1'b1;
        failures     = 0;
        quiet_cycles = 0;
        snd_idle_pct = 11;
        rcv_idle_pct = 78;
        foreach (list_mem[i])
            list_mem[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_ops[i])
            send_op(directed_ops[i].kind, directed_ops[i].value, directed_ops[i].index,
                    directed_ops[i].known, directed_ops[i].reply);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase > 0)
                wait_drained();
            snd_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 78 : 0;
            rcv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 11 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                // Fill toward full, dwell there a little, then drain toward empty.
                if (list_len >= DEPTH && $urandom_range(7) == 0)
                    growing = 1'b0;
                if (list_len == 0 && $urandom_range(3) == 0)
                    growing = 1'b1;
                roll = $urandom_range(99);
                if (growing)
                    kind = roll < 28 ? bve_pkg::KIND_APPEND
                         : roll < 46 ? bve_pkg::KIND_PREPEND
                         : roll < 62 ? bve_pkg::KIND_INSERT
                         : roll < 70 ? bve_pkg::KIND_TAKE_LAST
                         : roll < 76 ? bve_pkg::KIND_TAKE_FIRST
                         : roll < 87 ? bve_pkg::KIND_READ_AT
                         : roll < 98 ? bve_pkg::KIND_FIND : KIND_UNUSED;
                else
                    kind = roll < 6  ? bve_pkg::KIND_APPEND
                         : roll < 10 ? bve_pkg::KIND_PREPEND
                         : roll < 14 ? bve_pkg::KIND_INSERT
                         : roll < 44 ? bve_pkg::KIND_TAKE_LAST
                         : roll < 74 ? bve_pkg::KIND_TAKE_FIRST
                         : roll < 86 ? bve_pkg::KIND_READ_AT
                         : roll < 98 ? bve_pkg::KIND_FIND : KIND_UNUSED;

                case ($urandom_range(3))
                    0: value = bve_pkg::word_t'($urandom);
                    // A narrow range gives duplicate entries for find.
                    1: value = bve_pkg::word_t'($urandom_range(8)) - 32'sd4;
                    2: value = {1'($urandom_range(1)), {31{1'($urandom_range(1))}}};
                    default:
                        value = (list_len > 0) ? list_mem[$urandom_range(list_len - 1)]
                                               : bve_pkg::word_t'($urandom);
                endcase

                roll = $urandom_range(9);
                if (roll < 7)
                    index = bve_pkg::index_t'($urandom_range(list_len));
                else if (roll < 8)
                    index = bve_pkg::INDEX_FRONT;
                else
                    index = bve_pkg::index_t'($urandom);

                send_op(kind, value, index, 1'b0, '0);
                if (kind != KIND_UNUSED)
                    sent++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
